// ===== hdl/sms_pkg.sv =====
package sms_pkg;

  // Sizing
  localparam int MAX_SAMPLES = 1024;
  localparam int FRAC_BITS   = 16;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SAMPLE_W    = 32;
  localparam int SUM_W       = 48;
  localparam int WIDE_W      = 48;
  localparam int TOTAL_W     = 11;
  localparam int ACC_W       = 64;
  localparam int PROD_W      = 128;
  localparam int PAIR_W      = 2 * CNT_W + 2;
  localparam int TRIPLE_W    = PAIR_W + CNT_W;

  localparam logic [ACC_W-1:0]  ACC_MAX  = '1;
  localparam logic [WIDE_W-1:0] WIDE_MAX = '1;

  // Controller states
  typedef enum logic [5:0] {
    S_LOAD, S_MEAN_GO, S_MEAN_WAIT,
    S_RD1, S_DEV1, S_SQ_GO, S_SQ_WAIT,
    S_VAR_GO, S_VAR_WAIT, S_ROOT_GO, S_ROOT_WAIT,
    S_PREP1, S_PREP2, S_RD2, S_DEV2,
    S_Z_GO, S_Z_WAIT, S_Z2_GO, S_Z2_WAIT, S_Z3_GO, S_Z3_WAIT, S_Z4_GO, S_Z4_WAIT,
    S_SKM_GO, S_SKM_WAIT, S_SKD_GO, S_SKD_WAIT,
    S_K1M_GO, S_K1M_WAIT, S_K1D_GO, S_K1D_WAIT, S_K2_GO, S_K2_WAIT,
    S_FINISH
  } state_t;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MEAN_GO, OP_MEAN_END, OP_RD, OP_DEV,
    OP_SQ_GO, OP_SQ_END, OP_VAR_GO, OP_VAR_END, OP_ROOT_GO, OP_ROOT_END,
    OP_PREP1, OP_PREP2, OP_Z_GO, OP_Z_END, OP_Z2_GO, OP_Z2_END,
    OP_Z3_GO, OP_Z3_END, OP_Z4_GO, OP_Z4_END,
    OP_SKM_GO, OP_SKD_GO, OP_SK_END, OP_K1M_GO, OP_K1D_GO, OP_K1_END,
    OP_K2_GO, OP_K2_END, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic root_done;
    logic root_zero;
    logic idx_last;
    logic n_ge2;
    logic n_ge3;
    logic n_ge4;
    logic out_free;
  } status_t;

  // Saturating 64-bit add
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
  endfunction

  // floor(p / 2^F), saturating at 2^64-1
  function automatic logic [ACC_W-1:0] frac_sat(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] s;
    s = p >> FRAC_BITS;
    return (s[PROD_W-1:ACC_W] != '0) ? ACC_MAX : s[ACC_W-1:0];
  endfunction

  // Clamp a sign and magnitude to a signed 32-bit word
  function automatic logic [31:0] clamp32(input logic neg, input logic [ACC_W-1:0] mag);
    logic [ACC_W-1:0] nm;
    nm = '0 - mag;
    if (neg) begin
      return (mag >= 64'h8000_0000) ? 32'h8000_0000 : nm[31:0];
    end
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

endpackage

// ===== hdl/sms_if.sv =====
interface sms_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sms_pkg::SAMPLE_W-1:0]    sample;
  logic                                   last;
  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

interface sms_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [31:0]                     mean_value;
  logic [sms_pkg::WIDE_W-1:0]             variance_value;
  logic [sms_pkg::WIDE_W-1:0]             std_dev_value;
  logic signed [31:0]                     skew_value;
  logic signed [31:0]                     kurt_value;
  logic                                   variance_ok;
  logic                                   skew_ok;
  logic                                   kurt_ok;
  logic                                   dropped;
  logic [sms_pkg::TOTAL_W-1:0]            sample_total;
  modport source (output valid, mean_value, variance_value, std_dev_value, skew_value,
                  kurt_value, variance_ok, skew_ok, kurt_ok, dropped, sample_total,
                  input ready);
  modport sink   (input valid, mean_value, variance_value, std_dev_value, skew_value,
                  kurt_value, variance_ok, skew_ok, kurt_ok, dropped, sample_total,
                  output ready);
endinterface

// ===== hdl/sample_moment_statistics.sv =====
// Loading: one sample word per cycle while the block is in its load state.
// After the last word: the mean, then a squares pass over the samples, then variance and root,
// then a normalized pass (one serial 64-step divide and three 4-product multiplies per sample),
// then skew and kurtosis; later steps are skipped when there are too few samples or no deviation.
// The shared divider and multiplier are used in turn; one block is worked at a time.
// rst (synchronous, active high) clears counters, flags and the output valid.
module sample_moment_statistics (
  input  logic       clk,
  input  logic       rst,
  sms_in_if.sink     samples,
  sms_out_if.source  stats
);

  sms_pkg::cmd_t    cmd;
  sms_pkg::status_t status;

  sms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_last  (samples.last),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sms_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .sample (samples.sample),
    .stats  (stats)
  );

endmodule

// ===== hdl/sms_ram.sv =====
module sms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/sms_mul.sv =====
module sms_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sms_pkg::ACC_W-1:0]     a,
  input  logic [sms_pkg::ACC_W-1:0]     b,
  output logic                          done,
  output logic [sms_pkg::PROD_W-1:0]    prod
);

  logic [63:0]  opa, opb;
  logic [2:0]   step;
  logic         busy;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic         pp_vld;
  logic [31:0]  ah, bh;

  // Pick the 32-bit halves for this partial product
  assign ah = step[1] ? opa[63:32] : opa[31:0];
  assign bh = step[0] ? opb[63:32] : opb[31:0];

  // Control: four partial products, then a final accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      pp_vld <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        step   <= '0;
        pp_vld <= 1'b0;
      end else if (busy) begin
        pp_vld <= (step < 3'd4);
        step   <= step + 3'd1;
        if (step == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operands, partial product register and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      opa  <= a;
      opb  <= b;
      prod <= '0;
    end else if (busy) begin
      pp    <= ah * bh;
      pp_sh <= {1'b0, step[1]} + {1'b0, step[0]};
      if (pp_vld) begin
        prod <= prod + ({64'b0, pp} << {pp_sh, 5'b0});
      end
    end
  end

endmodule

// ===== hdl/sms_div.sv =====
module sms_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sms_pkg::PROD_W-1:0]    num,
  input  logic [sms_pkg::ACC_W-1:0]     den,
  output logic                          done,
  output logic [sms_pkg::ACC_W-1:0]     quo
);

  logic [63:0] hi, lo, dv;
  logic [5:0]  cnt;
  logic        busy;
  logic [63:0] hs;
  logic        take;

  // Restoring step: one quotient bit per cycle
  assign hs   = {hi[62:0], lo[63]};
  assign take = hi[63] || (hs >= dv);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= '0;
        // Saturate when the quotient cannot fit in 64 bits
        if (den == '0 || num[127:64] >= den) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi  <= num[127:64];
      lo  <= num[63:0];
      dv  <= den;
      quo <= (den == '0 || num[127:64] >= den) ? sms_pkg::ACC_MAX : '0;
    end else if (busy) begin
      lo  <= {lo[62:0], 1'b0};
      hi  <= take ? hs - dv : hs;
      quo <= {quo[62:0], take};
    end
  end

endmodule

// ===== hdl/sms_sqrt.sv =====
module sms_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sms_pkg::WIDE_W-1:0]    value,
  output logic                          done,
  output logic [sms_pkg::WIDE_W-1:0]    root
);

  logic [95:0] rad;
  logic [51:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [51:0] rem_s, trial;

  // Two radicand bits per step, one root bit out
  assign rem_s = {rem[49:0], rad[95:94]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(sms_pkg::WIDE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= 96'(value) << sms_pkg::FRAC_BITS;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[93:0], 2'b00};
      if (rem_s >= trial) begin
        rem  <= rem_s - trial;
        root <= {root[46:0], 1'b1};
      end else begin
        rem  <= rem_s;
        root <= {root[46:0], 1'b0};
      end
    end
  end

endmodule

// ===== hdl/sms_dp.sv =====
module sms_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sms_pkg::cmd_t                        cmd,
  output sms_pkg::status_t                     status,
  input  logic signed [sms_pkg::SAMPLE_W-1:0]  sample,
  sms_out_if.source                            stats
);

  localparam int CW = sms_pkg::CNT_W;
  localparam int AW = sms_pkg::ADDR_W;

  // Block accumulation
  logic [CW-1:0]                   fill;
  logic signed [sms_pkg::SUM_W-1:0] run_sum;
  logic                            ovf;
  logic [CW-1:0]                   idx;

  // Statistics under work
  logic signed [31:0]              mean;
  logic [32:0]                     dev_mag;
  logic                            dev_neg;
  logic [63:0]                     sumsq, pos3, neg3, sum4, z, z2, t1;
  logic [sms_pkg::WIDE_W-1:0]      var_r, sd;
  logic [31:0]                     skew, kurt;
  logic [sms_pkg::PAIR_W-1:0]      nm1nm2, nn1, nm1sq, den2b, t2num;
  logic [sms_pkg::TRIPLE_W-1:0]    den3;

  // Unit hookups
  logic                            mul_start, div_start, root_start;
  logic [63:0]                     mul_a, mul_b, div_den;
  logic [127:0]                    div_num, mul_prod;
  logic                            mul_done, div_done, root_done;
  logic [63:0]                     div_quo;
  logic [sms_pkg::WIDE_W-1:0]      root_val;
  logic [31:0]                     ram_rdata;
  logic                            ram_we;

  logic [CW-1:0]                   nm1, nm2, nm3;
  logic [sms_pkg::SUM_W-1:0]       sum_mag;
  logic [63:0]                     skew_mag, z3_cur;
  logic                            skew_neg;
  logic signed [32:0]              dev;

  assign nm1      = fill - CW'(1);
  assign nm2      = fill - CW'(2);
  assign nm3      = fill - CW'(3);
  assign sum_mag  = run_sum[sms_pkg::SUM_W-1] ? sms_pkg::SUM_W'(-run_sum)
                                               : sms_pkg::SUM_W'(run_sum);
  assign skew_neg = neg3 > pos3;
  assign skew_mag = skew_neg ? neg3 - pos3 : pos3 - neg3;
  assign dev      = $signed({ram_rdata[31], ram_rdata}) - $signed({mean[31], mean});
  assign z3_cur   = sms_pkg::frac_sat(mul_prod);
  assign ram_we   = (cmd.op == sms_pkg::OP_LOAD) && (fill < CW'(sms_pkg::MAX_SAMPLES));

  sms_ram #(.WIDTH(sms_pkg::SAMPLE_W), .DEPTH(sms_pkg::MAX_SAMPLES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill[AW-1:0]),
    .wdata (sample),
    .re    (cmd.op == sms_pkg::OP_RD),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  sms_mul u_mul (.clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
                 .done(mul_done), .prod(mul_prod));
  sms_div u_div (.clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
                 .done(div_done), .quo(div_quo));
  sms_sqrt u_sqrt (.clk(clk), .rst(rst), .start(root_start), .value(var_r),
                   .done(root_done), .root(root_val));

  // Route operands to the shared units
  always_comb begin
    mul_start  = 1'b1;
    div_start  = 1'b1;
    root_start = (cmd.op == sms_pkg::OP_ROOT_GO);
    mul_a      = '0;
    mul_b      = '0;
    div_num    = '0;
    div_den    = '0;
    unique case (cmd.op)
      sms_pkg::OP_SQ_GO:  begin mul_a = 64'(dev_mag); mul_b = 64'(dev_mag); end
      sms_pkg::OP_Z2_GO:  begin mul_a = z;  mul_b = z;  end
      sms_pkg::OP_Z3_GO:  begin mul_a = z2; mul_b = z;  end
      sms_pkg::OP_Z4_GO:  begin mul_a = z2; mul_b = z2; end
      sms_pkg::OP_SKM_GO: begin mul_a = skew_mag; mul_b = 64'(fill); end
      sms_pkg::OP_K1M_GO: begin mul_a = sum4; mul_b = 64'(nn1); end
      default:            mul_start = 1'b0;
    endcase
    unique case (cmd.op)
      sms_pkg::OP_MEAN_GO: begin div_num = 128'(sum_mag); div_den = 64'(fill); end
      sms_pkg::OP_VAR_GO:  begin div_num = 128'(sumsq);   div_den = 64'(nm1);  end
      sms_pkg::OP_Z_GO: begin
        div_num = 128'(dev_mag) << sms_pkg::FRAC_BITS;
        div_den = 64'(sd);
      end
      sms_pkg::OP_SKD_GO:  begin div_num = mul_prod; div_den = 64'(nm1nm2); end
      sms_pkg::OP_K1D_GO:  begin div_num = mul_prod; div_den = 64'(den3);   end
      sms_pkg::OP_K2_GO: begin
        div_num = 128'(t2num) << sms_pkg::FRAC_BITS;
        div_den = 64'(den2b);
      end
      default:             div_start = 1'b0;
    endcase
  end

  // Loading counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      run_sum <= '0;
      ovf     <= 1'b0;
    end else if (cmd.op == sms_pkg::OP_LOAD) begin
      if (fill < CW'(sms_pkg::MAX_SAMPLES)) begin
        fill    <= fill + CW'(1);
        run_sum <= run_sum + sms_pkg::SUM_W'(sample);
      end else begin
        ovf <= 1'b1;
      end
    end else if (cmd.op == sms_pkg::OP_FINISH) begin
      fill    <= '0;
      run_sum <= '0;
      ovf     <= 1'b0;
    end
  end

  // Statistics registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      sms_pkg::OP_MEAN_GO: begin
        idx   <= '0;
        sumsq <= '0;
        pos3  <= '0;
        neg3  <= '0;
        sum4  <= '0;
        var_r <= '0;
        sd    <= '0;
        skew  <= '0;
        kurt  <= '0;
      end
      sms_pkg::OP_MEAN_END:
        mean <= run_sum[sms_pkg::SUM_W-1] ? 32'('0 - div_quo) : div_quo[31:0];
      sms_pkg::OP_DEV: begin
        dev_neg <= dev[32];
        dev_mag <= dev[32] ? 33'(-dev) : 33'(dev);
      end
      sms_pkg::OP_SQ_END: begin
        sumsq <= sms_pkg::sat_add(sumsq, sms_pkg::frac_sat(mul_prod));
        idx   <= idx + CW'(1);
      end
      sms_pkg::OP_VAR_END:
        var_r <= (div_quo > 64'(sms_pkg::WIDE_MAX)) ? sms_pkg::WIDE_MAX
                                                    : div_quo[sms_pkg::WIDE_W-1:0];
      sms_pkg::OP_ROOT_END: sd <= root_val;
      sms_pkg::OP_PREP1: begin
        idx    <= '0;
        nm1nm2 <= sms_pkg::PAIR_W'(nm1) * sms_pkg::PAIR_W'(nm2);
        nn1    <= sms_pkg::PAIR_W'(fill) * (sms_pkg::PAIR_W'(fill) + sms_pkg::PAIR_W'(1));
        nm1sq  <= sms_pkg::PAIR_W'(nm1) * sms_pkg::PAIR_W'(nm1);
        den2b  <= sms_pkg::PAIR_W'(nm2) * sms_pkg::PAIR_W'(nm3);
      end
      sms_pkg::OP_PREP2: begin
        den3  <= sms_pkg::TRIPLE_W'(nm1nm2) * sms_pkg::TRIPLE_W'(nm3);
        t2num <= sms_pkg::PAIR_W'(3) * nm1sq;
      end
      sms_pkg::OP_Z_END:  z  <= div_quo;
      sms_pkg::OP_Z2_END: z2 <= sms_pkg::frac_sat(mul_prod);
      sms_pkg::OP_Z3_END: begin
        if (dev_neg) begin
          neg3 <= sms_pkg::sat_add(neg3, z3_cur);
        end else begin
          pos3 <= sms_pkg::sat_add(pos3, z3_cur);
        end
      end
      sms_pkg::OP_Z4_END: begin
        sum4 <= sms_pkg::sat_add(sum4, sms_pkg::frac_sat(mul_prod));
        idx  <= idx + CW'(1);
      end
      sms_pkg::OP_SK_END: skew <= sms_pkg::clamp32(skew_neg, div_quo);
      sms_pkg::OP_K1_END: t1 <= div_quo;
      sms_pkg::OP_K2_END:
        kurt <= (t1 >= div_quo) ? sms_pkg::clamp32(1'b0, t1 - div_quo)
                                : sms_pkg::clamp32(1'b1, div_quo - t1);
      default: ;
    endcase
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      stats.valid <= 1'b0;
    end else if (cmd.op == sms_pkg::OP_FINISH) begin
      stats.valid <= 1'b1;
    end else if (stats.ready) begin
      stats.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == sms_pkg::OP_FINISH) begin
      stats.mean_value     <= mean;
      stats.variance_value <= var_r;
      stats.std_dev_value  <= sd;
      stats.skew_value     <= skew;
      stats.kurt_value     <= kurt;
      stats.variance_ok    <= status.n_ge2;
      stats.skew_ok        <= status.n_ge3;
      stats.kurt_ok        <= status.n_ge4;
      stats.dropped        <= ovf;
      stats.sample_total   <= sms_pkg::TOTAL_W'(fill);
    end
  end

  // Status back to the controller
  always_comb begin
    status.mul_done  = mul_done;
    status.div_done  = div_done;
    status.root_done = root_done;
    status.root_zero = (root_val == '0);
    status.idx_last  = (idx == nm1);
    status.n_ge2     = (fill >= CW'(2));
    status.n_ge3     = (fill >= CW'(3));
    status.n_ge4     = (fill >= CW'(4));
    status.out_free  = !stats.valid || stats.ready;
  end

endmodule

// ===== hdl/sms_ctrl.sv =====
module sms_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  sms_pkg::status_t  status,
  output sms_pkg::cmd_t     cmd
);

  sms_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sms_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Sequence: load, mean, sum of squares, variance, root, cubic/quartic pass, skew, kurtosis, finish
  always_comb begin
    state_next = state;
    cmd.op     = sms_pkg::OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      sms_pkg::S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = sms_pkg::OP_LOAD;
          if (in_last) state_next = sms_pkg::S_MEAN_GO;
        end
      end
      sms_pkg::S_MEAN_GO: begin
        cmd.op = sms_pkg::OP_MEAN_GO; state_next = sms_pkg::S_MEAN_WAIT;
      end
      sms_pkg::S_MEAN_WAIT: if (status.div_done) begin
        cmd.op     = sms_pkg::OP_MEAN_END;
        state_next = status.n_ge2 ? sms_pkg::S_RD1 : sms_pkg::S_FINISH;
      end
      sms_pkg::S_RD1:   begin cmd.op = sms_pkg::OP_RD;    state_next = sms_pkg::S_DEV1;  end
      sms_pkg::S_DEV1:  begin cmd.op = sms_pkg::OP_DEV;   state_next = sms_pkg::S_SQ_GO; end
      sms_pkg::S_SQ_GO: begin cmd.op = sms_pkg::OP_SQ_GO; state_next = sms_pkg::S_SQ_WAIT; end
      sms_pkg::S_SQ_WAIT: if (status.mul_done) begin
        cmd.op     = sms_pkg::OP_SQ_END;
        state_next = status.idx_last ? sms_pkg::S_VAR_GO : sms_pkg::S_RD1;
      end
      sms_pkg::S_VAR_GO: begin
        cmd.op = sms_pkg::OP_VAR_GO; state_next = sms_pkg::S_VAR_WAIT;
      end
      sms_pkg::S_VAR_WAIT: if (status.div_done) begin
        cmd.op = sms_pkg::OP_VAR_END; state_next = sms_pkg::S_ROOT_GO;
      end
      sms_pkg::S_ROOT_GO: begin
        cmd.op = sms_pkg::OP_ROOT_GO; state_next = sms_pkg::S_ROOT_WAIT;
      end
      sms_pkg::S_ROOT_WAIT: if (status.root_done) begin
        cmd.op     = sms_pkg::OP_ROOT_END;
        state_next = (status.n_ge3 && !status.root_zero) ? sms_pkg::S_PREP1
                                                         : sms_pkg::S_FINISH;
      end
      sms_pkg::S_PREP1: begin cmd.op = sms_pkg::OP_PREP1; state_next = sms_pkg::S_PREP2; end
      sms_pkg::S_PREP2: begin cmd.op = sms_pkg::OP_PREP2; state_next = sms_pkg::S_RD2;   end
      sms_pkg::S_RD2:   begin cmd.op = sms_pkg::OP_RD;    state_next = sms_pkg::S_DEV2;  end
      sms_pkg::S_DEV2:  begin cmd.op = sms_pkg::OP_DEV;   state_next = sms_pkg::S_Z_GO;  end
      sms_pkg::S_Z_GO:  begin cmd.op = sms_pkg::OP_Z_GO;  state_next = sms_pkg::S_Z_WAIT; end
      sms_pkg::S_Z_WAIT: if (status.div_done) begin
        cmd.op = sms_pkg::OP_Z_END; state_next = sms_pkg::S_Z2_GO;
      end
      sms_pkg::S_Z2_GO: begin cmd.op = sms_pkg::OP_Z2_GO; state_next = sms_pkg::S_Z2_WAIT; end
      sms_pkg::S_Z2_WAIT: if (status.mul_done) begin
        cmd.op = sms_pkg::OP_Z2_END; state_next = sms_pkg::S_Z3_GO;
      end
      sms_pkg::S_Z3_GO: begin cmd.op = sms_pkg::OP_Z3_GO; state_next = sms_pkg::S_Z3_WAIT; end
      sms_pkg::S_Z3_WAIT: if (status.mul_done) begin
        cmd.op = sms_pkg::OP_Z3_END; state_next = sms_pkg::S_Z4_GO;
      end
      sms_pkg::S_Z4_GO: begin cmd.op = sms_pkg::OP_Z4_GO; state_next = sms_pkg::S_Z4_WAIT; end
      sms_pkg::S_Z4_WAIT: if (status.mul_done) begin
        cmd.op     = sms_pkg::OP_Z4_END;
        state_next = status.idx_last ? sms_pkg::S_SKM_GO : sms_pkg::S_RD2;
      end
      sms_pkg::S_SKM_GO: begin
        cmd.op = sms_pkg::OP_SKM_GO; state_next = sms_pkg::S_SKM_WAIT;
      end
      sms_pkg::S_SKM_WAIT: if (status.mul_done) state_next = sms_pkg::S_SKD_GO;
      sms_pkg::S_SKD_GO: begin
        cmd.op = sms_pkg::OP_SKD_GO; state_next = sms_pkg::S_SKD_WAIT;
      end
      sms_pkg::S_SKD_WAIT: if (status.div_done) begin
        cmd.op     = sms_pkg::OP_SK_END;
        state_next = status.n_ge4 ? sms_pkg::S_K1M_GO : sms_pkg::S_FINISH;
      end
      sms_pkg::S_K1M_GO: begin
        cmd.op = sms_pkg::OP_K1M_GO; state_next = sms_pkg::S_K1M_WAIT;
      end
      sms_pkg::S_K1M_WAIT: if (status.mul_done) state_next = sms_pkg::S_K1D_GO;
      sms_pkg::S_K1D_GO: begin
        cmd.op = sms_pkg::OP_K1D_GO; state_next = sms_pkg::S_K1D_WAIT;
      end
      sms_pkg::S_K1D_WAIT: if (status.div_done) begin
        cmd.op = sms_pkg::OP_K1_END; state_next = sms_pkg::S_K2_GO;
      end
      sms_pkg::S_K2_GO: begin cmd.op = sms_pkg::OP_K2_GO; state_next = sms_pkg::S_K2_WAIT; end
      sms_pkg::S_K2_WAIT: if (status.div_done) begin
        cmd.op = sms_pkg::OP_K2_END; state_next = sms_pkg::S_FINISH;
      end
      sms_pkg::S_FINISH: if (status.out_free) begin
        cmd.op = sms_pkg::OP_FINISH; state_next = sms_pkg::S_LOAD;
      end
      default: state_next = sms_pkg::S_LOAD;
    endcase
  end

endmodule

// ===== hdl/sms_checker.sv =====
module sms_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_last,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         variance_ok,
  input logic                         skew_ok,
  input logic                         kurt_ok,
  input logic [sms_pkg::WIDE_W-1:0]   variance_value,
  input logic [sms_pkg::WIDE_W-1:0]   std_dev_value,
  input logic [31:0]                  skew_value,
  input logic [31:0]                  kurt_value
);

  // Hold a result word until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before taken");

  // Stop taking samples once a block closes
  a_close: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("sample taken right after block close");

  // Validity flags nest by sample count
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!kurt_ok || skew_ok) && (!skew_ok || variance_ok))
    else $error("validity flags out of order");

  // Too few samples gives zero spread
  a_few: assert property (@(posedge clk) disable iff (rst)
    out_valid && !variance_ok |-> variance_value == '0 && std_dev_value == '0)
    else $error("spread nonzero with fewer than two samples");

  // Zero deviation gives zero shape statistics
  a_flat: assert property (@(posedge clk) disable iff (rst)
    out_valid && std_dev_value == '0 |-> skew_value == '0 && kurt_value == '0)
    else $error("shape statistics nonzero with zero deviation");

endmodule

bind sample_moment_statistics sms_checker u_sms_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (samples.valid),
  .in_ready       (samples.ready),
  .in_last        (samples.last),
  .out_valid      (stats.valid),
  .out_ready      (stats.ready),
  .variance_ok    (stats.variance_ok),
  .skew_ok        (stats.skew_ok),
  .kurt_ok        (stats.kurt_ok),
  .variance_value (stats.variance_value),
  .std_dev_value  (stats.std_dev_value),
  .skew_value     (stats.skew_value),
  .kurt_value     (stats.kurt_value)
);

// ===== bench/sample_moment_statistics_tb.sv =====
`timescale 1ns / 1ps

module sample_moment_statistics_tb;

  typedef struct {
    logic [31:0] mean;
    logic [47:0] var_v;
    logic [47:0] sd;
    logic [31:0] skew;
    logic [31:0] kurt;
    bit          var_ok;
    bit          skew_ok;
    bit          kurt_ok;
    bit          dropped;
    logic [10:0] total;
  } moments_t;

  // flags: {var_ok, skew_ok, kurt_ok, dropped}
  typedef struct {
    logic [31:0] smp;
    bit          lst;
    bit          typed;
    logic [31:0] mean;
    logic [47:0] var_v;
    logic [10:0] total;
    logic [3:0]  flags;
  } row_t;

  logic clk = 0;
  logic rst = 1;

  sms_in_if  samp_if();
  sms_out_if stat_if();

  sample_moment_statistics DUT (
    .clk(clk),
    .rst(rst),
    .samples(samp_if),
    .stats(stat_if)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  moments_t            stats_due[$];
  logic signed [31:0]  block_words[$];
  bit                  block_dropped;
  int                  errors;
  int                  src_idle_pct;
  int                  snk_idle_pct;
  int                  hold_req;
  int                  hold_done;
  int                  hold_cnt;

  // ---------------------------------------------------------------- arithmetic
  function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // floor(a*b/d), saturating
  function automatic logic [63:0] mdiv(logic [63:0] a, logic [63:0] b, logic [63:0] d);
    logic [127:0] p;
    logic [127:0] q;
    if (d == 0) return '1;
    p = {64'b0, a} * {64'b0, b};
    q = p / {64'b0, d};
    return (q[127:64] != 0) ? '1 : q[63:0];
  endfunction

  function automatic logic [31:0] clip32(bit neg, logic [63:0] mag);
    logic [63:0] nm;
    nm = 64'd0 - mag;
    if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : nm[31:0];
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  // Statistics of one closed block
  function automatic moments_t block_moments(logic signed [31:0] xs[$], bit drp);
    moments_t    r;
    logic [63:0] n, sumsq, v, sd, m, z, z2, z3, pos3, neg3, sum4, mag, t1, t2;
    logic [127:0] sq;
    longint      sum, mean, d;
    bit          neg;
    n = xs.size();
    sum = 0;
    foreach (xs[i]) sum += xs[i];
    mean = (n != 0) ? sum / longint'(n) : 0;
    sumsq = 0; v = 0; sd = 0; pos3 = 0; neg3 = 0; sum4 = 0;
    r.skew = 0;
    r.kurt = 0;
    if (n >= 2) begin
      foreach (xs[i]) begin
        d = xs[i] - mean;
        m = (d < 0) ? -d : d;
        sumsq = sadd(sumsq, mdiv(m, m, 64'd1 << sms_pkg::FRAC_BITS));
      end
      v = sumsq / (n - 1);
      if (v > 64'hFFFF_FFFF_FFFF) v = 64'hFFFF_FFFF_FFFF;
      for (int b = 47; b >= 0; b--) begin
        sq = {64'b0, sd | (64'd1 << b)} * {64'b0, sd | (64'd1 << b)};
        if (sq <= ({64'b0, v} << sms_pkg::FRAC_BITS)) sd = sd | (64'd1 << b);
      end
    end
    if (n >= 3 && sd != 0) begin
      foreach (xs[i]) begin
        d = xs[i] - mean;
        m = (d < 0) ? -d : d;
        z = (m << sms_pkg::FRAC_BITS) / sd;
        z2 = mdiv(z, z, 64'd1 << sms_pkg::FRAC_BITS);
        z3 = mdiv(z2, z, 64'd1 << sms_pkg::FRAC_BITS);
        if (d < 0) neg3 = sadd(neg3, z3);
        else pos3 = sadd(pos3, z3);
        sum4 = sadd(sum4, mdiv(z2, z2, 64'd1 << sms_pkg::FRAC_BITS));
      end
      neg = neg3 > pos3;
      mag = neg ? neg3 - pos3 : pos3 - neg3;
      r.skew = clip32(neg, mdiv(mag, n, (n - 1) * (n - 2)));
      if (n >= 4) begin
        t1 = mdiv(sum4, n * (n + 1), (n - 1) * (n - 2) * (n - 3));
        t2 = mdiv(3 * (n - 1) * (n - 1), 64'd1 << sms_pkg::FRAC_BITS, (n - 2) * (n - 3));
        r.kurt = (t1 >= t2) ? clip32(0, t1 - t2) : clip32(1, t2 - t1);
      end
    end
    r.mean    = mean[31:0];
    r.var_v   = v[47:0];
    r.sd      = sd[47:0];
    r.var_ok  = n >= 2;
    r.skew_ok = n >= 3;
    r.kurt_ok = n >= 4;
    r.dropped = drp;
    r.total   = n[10:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- sender
  // Offer one word, hold until taken, then book it into the current block.
  task automatic send_word(logic [31:0] smp, bit lst, bit typed, moments_t typed_res);
    moments_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      samp_if.valid <= 1'b0;
      @(posedge clk);
    end
    samp_if.valid  <= 1'b1;
    samp_if.sample <= smp;
    samp_if.last   <= lst;
    @(posedge clk);
    while (!samp_if.ready) @(posedge clk);
    if (block_words.size() < sms_pkg::MAX_SAMPLES) block_words.push_back(smp);
    else block_dropped = 1;
    if (lst) begin
      res = block_moments(block_words, block_dropped);
      stats_due.push_back(typed ? typed_res : res);
      block_words.delete();
      block_dropped = 0;
    end
  endtask

  task automatic send_plain(logic [31:0] smp, bit lst);
    moments_t none;
    none = '{default: '0};
    send_word(smp, lst, 0, none);
  endtask

  function automatic logic [31:0] pick_sample(int kind, logic [31:0] base);
    case (kind)
      0: return $urandom;
      1: return base + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2: return base;
      default: return $urandom_range(1) ? 32'h7FFF_0000 | $urandom_range(16'hFFFF)
                                        : 32'h8000_0000 | $urandom_range(16'hFFFF);
    endcase
  endfunction

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (rst) begin
      stat_if.ready <= 1'b0;
    end else if (hold_req != hold_done) begin
      hold_done = hold_req;
      hold_cnt = 3000;
      stat_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      stat_if.ready <= 1'b0;
    end else begin
      stat_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic note_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    moments_t w;
    if (!rst && stat_if.valid && stat_if.ready) begin
      if (stats_due.size() == 0) begin
        note_mismatch("unexpected word", 0, 0);
      end else begin
        w = stats_due.pop_front();
        if (stat_if.mean_value !== w.mean) note_mismatch("mean", stat_if.mean_value, w.mean);
        if (stat_if.variance_value !== w.var_v)
          note_mismatch("variance", stat_if.variance_value, w.var_v);
        if (stat_if.std_dev_value !== w.sd) note_mismatch("std_dev", stat_if.std_dev_value, w.sd);
        if (stat_if.skew_value !== w.skew) note_mismatch("skew", stat_if.skew_value, w.skew);
        if (stat_if.kurt_value !== w.kurt) note_mismatch("kurt", stat_if.kurt_value, w.kurt);
        if (stat_if.variance_ok !== w.var_ok)
          note_mismatch("variance_ok", stat_if.variance_ok, w.var_ok);
        if (stat_if.skew_ok !== w.skew_ok) note_mismatch("skew_ok", stat_if.skew_ok, w.skew_ok);
        if (stat_if.kurt_ok !== w.kurt_ok) note_mismatch("kurt_ok", stat_if.kurt_ok, w.kurt_ok);
        if (stat_if.dropped !== w.dropped) note_mismatch("dropped", stat_if.dropped, w.dropped);
        if (stat_if.sample_total !== w.total)
          note_mismatch("sample_total", stat_if.sample_total, w.total);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  row_t plan[] = '{
    '{32'h7FFF_FFFF, 1, 1, 32'h7FFF_FFFF, 48'd0, 11'd1, 4'b0000},
    '{32'h8000_0000, 1, 1, 32'h8000_0000, 48'd0, 11'd1, 4'b0000},
    '{32'h0001_0000, 0, 0, 0, 0, 0, 0},
    '{32'h0001_0000, 1, 1, 32'h0001_0000, 48'd0, 11'd2, 4'b1000},
    '{32'hFFFF_0000, 0, 0, 0, 0, 0, 0},
    '{32'hFFFF_0000, 0, 0, 0, 0, 0, 0},
    '{32'hFFFF_0000, 1, 1, 32'hFFFF_0000, 48'd0, 11'd3, 4'b1100},
    '{32'h0000_0000, 0, 0, 0, 0, 0, 0},
    '{32'h0000_0000, 0, 0, 0, 0, 0, 0},
    '{32'h0000_0000, 0, 0, 0, 0, 0, 0},
    '{32'h0000_0000, 1, 1, 32'h0000_0000, 48'd0, 11'd4, 4'b1110},
    '{32'h8000_0000, 0, 0, 0, 0, 0, 0},
    '{32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0},
    '{32'h8000_0000, 0, 0, 0, 0, 0, 0},
    '{32'h7FFF_FFFF, 1, 0, 0, 0, 0, 0},
    '{32'h0000_0001, 0, 0, 0, 0, 0, 0},
    '{32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0},
    '{32'h0004_0000, 0, 0, 0, 0, 0, 0},
    '{32'h0000_0000, 0, 0, 0, 0, 0, 0},
    '{32'hFFFD_0000, 1, 0, 0, 0, 0, 0},
    '{32'h0000_0000, 0, 0, 0, 0, 0, 0},
    '{32'h5555_AAAA, 0, 0, 0, 0, 0, 0},
    '{32'h2AAA_5555, 0, 0, 0, 0, 0, 0},
    '{32'hAAAA_5555, 1, 0, 0, 0, 0, 0}
  };

  initial begin
    moments_t    tr;
    int          made, len, kind;
    bit          overflow_done;
    logic [31:0] base;
    errors = 0; hold_req = 0; hold_done = 0; hold_cnt = 0;
    block_dropped = 0; overflow_done = 0;
    src_idle_pct = 13; snk_idle_pct = 71;
    samp_if.valid = 0; samp_if.sample = 0; samp_if.last = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (plan[i]) begin
      tr = '{default: '0};
      tr.mean = plan[i].mean;
      tr.var_v = plan[i].var_v;
      tr.total = plan[i].total;
      {tr.var_ok, tr.skew_ok, tr.kurt_ok, tr.dropped} = plan[i].flags;
      send_word(plan[i].smp, plan[i].lst, plan[i].typed, tr);
    end

    // Random blocks, idle pattern swapped by thirds, last third with no idle after a long receiver pause
    made = 0;
    while (made < 850) begin
      if (made >= 280 && made < 560) begin
        src_idle_pct = 71; snk_idle_pct = 13;
      end else if (made >= 560 && src_idle_pct != 0) begin
        src_idle_pct = 0; snk_idle_pct = 0;
        hold_req++;
      end
      if (!overflow_done && made >= 400) begin
        // Overfill the store, closing word dropped too
        overflow_done = 1;
        for (int k = 0; k < sms_pkg::MAX_SAMPLES + 5; k++)
          send_plain($urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
                     k == sms_pkg::MAX_SAMPLES + 4);
      end
      len = $urandom_range(99);
      len = (len < 85) ? $urandom_range(1, 10) : (len < 97) ? $urandom_range(11, 40)
                                                             : $urandom_range(41, 120);
      kind = $urandom_range(3);
      base = $urandom;
      for (int k = 0; k < len; k++) send_plain(pick_sample(kind, base), k == len - 1);
      made += len;
    end
    samp_if.valid <= 1'b0;

    while (stats_due.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
